/* hdl/mep_pkg.sv */
// ============================================================================
// Mandelbrot escape-time pixel package
// Shared widths, fixed-point format, register indexes, reset values and
// sequencer state codes for the escape-time pixel evaluator.
// ============================================================================
package mep_pkg;

    // Fixed-point format of the complex plane (signed, Q4.28 by default)
    localparam int FRAC_BITS   = 28;

    // Field and register widths
    localparam int COL_W       = 9;
    localparam int ROW_W       = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int ORIGIN_W    = 32;
    localparam int STEP_W      = 31;
    localparam int COUNT_W     = 12;
    localparam int COLOR_W     = 24;

    // Iteration limits
    localparam int MAX_ITER_DEFAULT = 2048;
    localparam int GRAY_LIMIT       = 255;

    // Point c: signed origin plus an unsigned offset of up to COL_W+STEP_W bits
    localparam int C_W = COL_W + STEP_W + 2;
    // Iterate z: one more bit to hold sums of the truncated products and c
    localparam int Z_W = C_W + 1;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RE_ORIGIN  = 3'd0,
        CFG_RE_STEP    = 3'd1,
        CFG_IM_ORIGIN  = 3'd2,
        CFG_IM_STEP    = 3'd3,
        CFG_COLOR_MODE = 3'd4
    } mep_cfg_index_t;

    // Reset values: view -2.5..1.0 by -1.0..1.0 on 400x240, colour mode
    localparam logic signed [ORIGIN_W-1:0] RE_ORIGIN_RESET  = -32'sd671088640;
    localparam logic [STEP_W-1:0]          RE_STEP_RESET    = 31'd2348810;
    localparam logic signed [ORIGIN_W-1:0] IM_ORIGIN_RESET  = -32'sd268435456;
    localparam logic [STEP_W-1:0]          IM_STEP_RESET    = 31'd2236962;
    localparam logic                       COLOR_MODE_RESET = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_MUL   = 4'b0100,
        ST_UPD   = 4'b1000
    } mep_state_t;

endpackage

/* hdl/mandelbrot_escape_pixel.sv */
// ============================================================================
// Mandelbrot escape-time pixel evaluator
// Maps a pixel to c = origin + index*step and iterates z = z*z + c from zero
// until |z|^2 >= 4 or the mode's limit, then returns the count and a colour.
// ============================================================================
// Operation: an accepted pixel passes through setup; each iteration then runs
// the shared squaring unit and then the update/escape adder, and the done
// strobe is registered from the finishing step. The block takes no new pixel
// while busy, and busy stays high until done; the result strobe cannot be
// stalled.
// Reset clears the sequencer and restores the default view and colour mode.
module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Pixel command
    input  logic                   start,
    output logic                   busy,
    input  logic [COL_W-1:0]       col,
    input  logic [ROW_W-1:0]       row,
    // Result
    output logic                   done,
    output logic [COUNT_W-1:0]     iter_count,
    output logic [COLOR_W-1:0]     pixel_color
);

    // Iteration counter wide enough for both limits
    localparam int CNT_RAW_W = $clog2(MAX_ITER + 1);
    localparam int CNT_W     = (CNT_RAW_W > 8) ? CNT_RAW_W : 8;
    localparam int RE_OFF_W  = COL_W + STEP_W;
    localparam int IM_OFF_W  = ROW_W + STEP_W;
    localparam int MAG_W     = FRAC_BITS + 1;      // |z| < 2 after bound check
    localparam int PROD_W    = 2 * MAG_W;
    localparam int SQ_W      = FRAC_BITS + 2;      // truncated square < 4
    localparam int XM_W      = FRAC_BITS + 3;      // truncated |2*zr*zi| < 8
    localparam int XS_W      = XM_W + 1;

    localparam logic signed [Z_W-1:0] Z_TWO  = Z_W'(64'd1 << (FRAC_BITS + 1));
    localparam logic [SQ_W:0]         SQ_FOUR = (SQ_W+1)'(64'd1 << (FRAC_BITS + 2));

    // Configuration registers
    logic signed [ORIGIN_W-1:0] re_origin_reg;
    logic [STEP_W-1:0]          re_step_reg;
    logic signed [ORIGIN_W-1:0] im_origin_reg;
    logic [STEP_W-1:0]          im_step_reg;
    logic                       color_mode_reg;

    // Sequencer and datapath registers
    mep_state_t               state_reg, state_next;
    logic [COL_W-1:0]         col_reg;
    logic [ROW_W-1:0]         row_reg;
    logic signed [C_W-1:0]    cr_reg, ci_reg;
    logic signed [Z_W-1:0]    zr_reg, zr_next;
    logic signed [Z_W-1:0]    zi_reg, zi_next;
    logic [SQ_W-1:0]          sr_reg, si_reg;
    logic signed [XS_W-1:0]   xp_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         limit_reg;
    logic                     done_reg, done_next;
    logic [COUNT_W-1:0]       iter_count_reg;
    logic [COLOR_W-1:0]       pixel_color_reg;

    logic                     accept;
    logic                     finish;
    logic [RE_OFF_W-1:0]      re_off;
    logic [IM_OFF_W-1:0]      im_off;
    logic                     out_of_range;
    logic [Z_W-1:0]           zr_abs, zi_abs;
    logic [MAG_W-1:0]         zr_mag, zi_mag;
    logic [PROD_W-1:0]        prod_rr, prod_ii, prod_ri;
    logic [XM_W-1:0]          xp_mag;
    logic                     xp_neg;
    logic [SQ_W:0]            sq_sum;
    logic [31:0]              cnt_wide;
    logic [7:0]               cnt_lo, cnt_hi;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_origin_reg  <= RE_ORIGIN_RESET;
            re_step_reg    <= RE_STEP_RESET;
            im_origin_reg  <= IM_ORIGIN_RESET;
            im_step_reg    <= IM_STEP_RESET;
            color_mode_reg <= COLOR_MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RE_ORIGIN:  re_origin_reg  <= signed'(cfg_data[ORIGIN_W-1:0]);
                CFG_RE_STEP:    re_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_IM_ORIGIN:  im_origin_reg  <= signed'(cfg_data[ORIGIN_W-1:0]);
                CFG_IM_STEP:    im_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Pixel offsets from the origin, formed once per pixel in the setup cycle
    assign re_off = RE_OFF_W'(col_reg) * RE_OFF_W'(re_step_reg);
    assign im_off = IM_OFF_W'(row_reg) * IM_OFF_W'(im_step_reg);

    // Bound check: a component already at or beyond 2 escapes without squaring
    assign out_of_range = (zr_reg >= Z_TWO) || (zr_reg <= -Z_TWO) ||
                          (zi_reg >= Z_TWO) || (zi_reg <= -Z_TWO);

    // Shared squaring unit: magnitudes, exact products, truncation, sign
    assign zr_abs  = zr_reg[Z_W-1] ? Z_W'(-zr_reg) : Z_W'(zr_reg);
    assign zi_abs  = zi_reg[Z_W-1] ? Z_W'(-zi_reg) : Z_W'(zi_reg);
    assign zr_mag  = zr_abs[MAG_W-1:0];
    assign zi_mag  = zi_abs[MAG_W-1:0];
    assign prod_rr = PROD_W'(zr_mag) * PROD_W'(zr_mag);
    assign prod_ii = PROD_W'(zi_mag) * PROD_W'(zi_mag);
    assign prod_ri = PROD_W'(zr_mag) * PROD_W'(zi_mag);
    // Doubling zr is folded into a shift one place shorter
    assign xp_mag  = prod_ri[FRAC_BITS+XM_W-2:FRAC_BITS-1];
    assign xp_neg  = zr_reg[Z_W-1] != zi_reg[Z_W-1];

    // Escape test on the truncated squares
    assign sq_sum = (SQ_W+1)'(sr_reg) + (SQ_W+1)'(si_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        cnt_next   = cnt_reg;
        finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                zr_next    = '0;
                zi_next    = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if ((cnt_reg >= limit_reg) || out_of_range)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (sq_sum >= SQ_FOUR)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    zr_next    = signed'(Z_W'(sr_reg)) - signed'(Z_W'(si_reg)) +
                                 Z_W'(cr_reg);
                    zi_next    = Z_W'(xp_reg) + Z_W'(ci_reg);
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done_next = finish;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        zr_reg  <= zr_next;
        zi_reg  <= zi_next;
        cnt_reg <= cnt_next;
        if (accept)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        if (state_reg == ST_SETUP)
        begin
            cr_reg    <= C_W'(re_origin_reg) + signed'(C_W'(re_off));
            ci_reg    <= C_W'(im_origin_reg) + signed'(C_W'(im_off));
            limit_reg <= color_mode_reg ? CNT_W'(MAX_ITER) : CNT_W'(GRAY_LIMIT);
        end
        if (state_reg == ST_MUL)
        begin
            sr_reg <= prod_rr[FRAC_BITS+SQ_W-1:FRAC_BITS];
            si_reg <= prod_ii[FRAC_BITS+SQ_W-1:FRAC_BITS];
            xp_reg <= xp_neg ? -signed'(XS_W'(xp_mag)) : signed'(XS_W'(xp_mag));
        end
    end

    // Result formatting from the final count
    assign cnt_wide = 32'(cnt_reg);
    assign cnt_lo   = cnt_wide[7:0];
    assign cnt_hi   = cnt_wide[15:8];

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            iter_count_reg <= cnt_wide[COUNT_W-1:0];
            if (color_mode_reg)
            begin
                pixel_color_reg <= {cnt_hi, 8'd0, cnt_lo};
            end
            else
            begin
                pixel_color_reg <= {cnt_lo, cnt_lo, cnt_lo};
            end
        end
    end

    assign done        = done_reg;
    assign iter_count  = iter_count_reg;
    assign pixel_color = pixel_color_reg;

    // A result transfer only follows the last step of a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_MUL || $past(state_reg) == ST_UPD))
        else $error("result strobe without a finishing step");

    // The block is free again in the cycle that carries the result
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("busy while presenting a result");

    // The iteration count never passes the limit taken at setup
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_UPD) |-> (cnt_reg <= limit_reg))
        else $error("iteration count beyond limit");

    // An accepted pixel always enters setup next
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SETUP))
        else $error("accepted pixel did not start setup");

endmodule

/* verif/mandelbrot_escape_pixel_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// Mandelbrot escape-time pixel evaluator testbench
// Drives pixel commands and register writes from a command queue, predicts
// each escape count and colour with an independent fixed-point model of the
// iteration, and checks every result strobe against the oldest prediction.
// ============================================================================
module mandelbrot_escape_pixel_test;
    import mep_pkg::*;

    localparam int     ITER_LIMIT   = MAX_ITER_DEFAULT;
    localparam int     SCREEN_W     = 400;
    localparam int     SCREEN_H     = 240;
    localparam int     ONE_FX       = 1 << FRAC_BITS;
    localparam longint TWO_FX       = longint'(2) << FRAC_BITS;
    localparam longint FOUR_FX      = longint'(4) << FRAC_BITS;
    localparam int     RAND_PHASES  = 10;
    localparam int     PHASE_PIXELS = 27;
    localparam int     TAIL_CYCLES  = 2 * ITER_LIMIT + 4;
    localparam longint TIMEOUT_NS   = 50_000_000;

    typedef enum logic { CMD_PIXEL, CMD_WRITE } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   calm;
        logic [COL_W-1:0]       col;
        logic [ROW_W-1:0]       row;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } stim_cmd_t;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [COUNT_W-1:0] count;
        logic [COLOR_W-1:0] color;
    } pixel_result_t;

    // Block ports
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic [COL_W-1:0]       col       = '0;
    logic [ROW_W-1:0]       row       = '0;
    logic                   done;
    logic [COUNT_W-1:0]     iter_count;
    logic [COLOR_W-1:0]     pixel_color;

    // Predictor copy of the view registers
    logic signed [ORIGIN_W-1:0] view_re_origin;
    logic [STEP_W-1:0]          view_re_step;
    logic signed [ORIGIN_W-1:0] view_im_origin;
    logic [STEP_W-1:0]          view_im_step;
    logic                       view_colour;

    stim_cmd_t     pending_cmds[$];
    pixel_result_t expected_pixels[$];

    logic pixel_taken  = 1'b0;
    int   idle_left    = 0;
    int   n_errors     = 0;
    int   n_checked    = 0;
    int   n_writes     = 0;
    int   n_gray       = 0;
    int   n_colour     = 0;

    mandelbrot_escape_pixel #(
        .MAX_ITER    (ITER_LIMIT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .col         (col),
        .row         (row),
        .done        (done),
        .iter_count  (iter_count),
        .pixel_color (pixel_color)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset is asserted from time zero and released on a falling edge.
    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
    end

    // Fixed-point product: truncate the magnitude, then apply the sign.
    function automatic longint fix_mul(input longint a, input longint b);
        longint ua;
        longint ub;
        longint mag;
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = (ua * ub) >>> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    // Escape count and colour of one pixel under the current view.
    function automatic pixel_result_t escape_pixel(input logic [COL_W-1:0] px_col,
                                                   input logic [ROW_W-1:0] px_row);
        longint        cr;
        longint        ci;
        longint        zr;
        longint        zi;
        longint        sq_re;
        longint        sq_im;
        longint        next_zi;
        int            limit;
        int            n;
        logic          escaped;
        pixel_result_t res;
        cr      = longint'(view_re_origin) + longint'(px_col) * longint'(view_re_step);
        ci      = longint'(view_im_origin) + longint'(px_row) * longint'(view_im_step);
        limit   = view_colour ? ITER_LIMIT : GRAY_LIMIT;
        zr      = 0;
        zi      = 0;
        n       = 0;
        escaped = 1'b0;
        while (n < limit && !escaped)
        begin
            // A component already at two or beyond escapes before squaring.
            if (zr >= TWO_FX || zr <= -TWO_FX || zi >= TWO_FX || zi <= -TWO_FX)
                escaped = 1'b1;
            else
            begin
                sq_re = fix_mul(zr, zr);
                sq_im = fix_mul(zi, zi);
                if (sq_re + sq_im >= FOUR_FX)
                    escaped = 1'b1;
                else
                begin
                    next_zi = fix_mul(2 * zr, zi) + ci;
                    zr      = sq_re - sq_im + cr;
                    zi      = next_zi;
                    n++;
                end
            end
        end
        res.col   = px_col;
        res.row   = px_row;
        res.count = n[COUNT_W-1:0];
        if (view_colour)
            res.color = {n[15:8], 8'h00, n[7:0]};
        else
            res.color = {3{n[7:0]}};
        return res;
    endfunction

    task automatic push_pixel(input int px_col,
                              input int px_row,
                              input logic calm);
        stim_cmd_t cmd;
        cmd      = '0;
        cmd.kind = CMD_PIXEL;
        cmd.calm = calm;
        cmd.col  = px_col[COL_W-1:0];
        cmd.row  = px_row[ROW_W-1:0];
        pending_cmds.push_back(cmd);
    endtask

    task automatic push_write(input logic [CFG_INDEX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] data);
        stim_cmd_t cmd;
        cmd       = '0;
        cmd.kind  = CMD_WRITE;
        cmd.index = index;
        cmd.data  = data;
        pending_cmds.push_back(cmd);
    endtask

    task automatic push_view(input logic [CFG_DATA_W-1:0] re_origin,
                             input logic [CFG_DATA_W-1:0] re_step,
                             input logic [CFG_DATA_W-1:0] im_origin,
                             input logic [CFG_DATA_W-1:0] im_step);
        push_write(CFG_RE_ORIGIN, re_origin);
        push_write(CFG_RE_STEP, re_step);
        push_write(CFG_IM_ORIGIN, im_origin);
        push_write(CFG_IM_STEP, im_step);
    endtask

    // Driver: presents commands on the falling edge. A pixel is held until its
    // transfer; a register write waits until the block is idle and drained.
    always @(negedge clk)
    begin : drive
        logic      next_start;
        logic      next_we;
        stim_cmd_t cmd;
        next_start = start;
        next_we    = 1'b0;
        if (start && pixel_taken)
            next_start = 1'b0;
        if (rst_n && !next_start && !cfg_we)
        begin
            if (idle_left > 0)
                idle_left = idle_left - 1;
            else if (pending_cmds.size() > 0)
            begin
                if (pending_cmds[0].kind == CMD_PIXEL)
                begin
                    cmd        = pending_cmds.pop_front();
                    next_start = 1'b1;
                    col       <= cmd.col;
                    row       <= cmd.row;
                    // Idle burst after this transfer, except near the end.
                    if (!cmd.calm && $urandom_range(0, 2) == 0)
                        idle_left = $urandom_range(1, 14);
                end
                else if (expected_pixels.size() == 0 && !busy)
                begin
                    cmd        = pending_cmds.pop_front();
                    next_we    = 1'b1;
                    cfg_index <= cmd.index;
                    cfg_data  <= cmd.data;
                end
            end
        end
        start  <= next_start;
        cfg_we <= next_we;
    end

    // Monitor: applies register writes to the predictor, predicts on each
    // pixel transfer and checks each result strobe on the rising edge.
    always @(posedge clk)
    begin : observe
        pixel_result_t want;
        if (!rst_n)
        begin
            view_re_origin = RE_ORIGIN_RESET;
            view_re_step   = RE_STEP_RESET;
            view_im_origin = IM_ORIGIN_RESET;
            view_im_step   = IM_STEP_RESET;
            view_colour    = COLOR_MODE_RESET;
            pixel_taken    = 1'b0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result, got count %0d colour %06h",
                             $time, iter_count, pixel_color);
                    n_errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (iter_count !== want.count)
                    begin
                        $display("%0t: pixel (%0d,%0d) iter_count expected %0d, got %0d",
                                 $time, want.col, want.row, want.count, iter_count);
                        n_errors++;
                    end
                    if (pixel_color !== want.color)
                    begin
                        $display("%0t: pixel (%0d,%0d) pixel_color expected %06h, got %06h",
                                 $time, want.col, want.row, want.color, pixel_color);
                        n_errors++;
                    end
                    n_checked++;
                end
            end

            // Bits above a register's width and unused indexes are ignored.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RE_ORIGIN:  view_re_origin = cfg_data;
                    CFG_RE_STEP:    view_re_step   = cfg_data[STEP_W-1:0];
                    CFG_IM_ORIGIN:  view_im_origin = cfg_data;
                    CFG_IM_STEP:    view_im_step   = cfg_data[STEP_W-1:0];
                    CFG_COLOR_MODE: view_colour    = cfg_data[0];
                    default:        ;
                endcase
                n_writes++;
            end

            pixel_taken = start && !busy;
            if (pixel_taken)
            begin
                expected_pixels.push_back(escape_pixel(col, row));
                if (view_colour)
                    n_colour++;
                else
                    n_gray++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        int   phase;
        int   k;
        logic colour;
        logic calm;

        // Reset view in colour mode: saturating escape at column zero, an
        // interior point, the screen corners and a pixel beyond the screen.
        push_pixel(0, 0, 1'b0);
        push_pixel(SCREEN_W - 1, SCREEN_H - 1, 1'b0);
        push_pixel(SCREEN_W / 2, SCREEN_H / 2, 1'b0);
        push_pixel((1 << COL_W) - 1, (1 << ROW_W) - 1, 1'b0);
        push_pixel(300, 100, 1'b0);

        // Gray mode selected by a write whose upper bits are all set.
        push_write(CFG_COLOR_MODE, 32'hFFFF_FFFE);
        push_pixel(SCREEN_W / 2, SCREEN_H / 2, 1'b0);
        push_pixel(0, (1 << ROW_W) - 1, 1'b0);
        push_pixel((1 << COL_W) - 1, 0, 1'b0);

        // Extreme origins with zero steps.
        push_view(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
        push_pixel(0, 0, 1'b0);
        push_pixel((1 << COL_W) - 1, (1 << ROW_W) - 1, 1'b0);

        // Largest steps, written with the unused top bit set, from the origin.
        push_view(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        push_pixel(0, 0, 1'b0);
        push_pixel(1, 0, 1'b0);
        push_pixel(0, 1, 1'b0);
        push_pixel((1 << COL_W) - 1, (1 << ROW_W) - 1, 1'b0);

        // Writes to indexes beyond the register list must change nothing.
        for (int idx = CFG_COLOR_MODE + 1; idx < (1 << CFG_INDEX_W); idx++)
            push_write(idx[CFG_INDEX_W-1:0], $urandom);
        push_pixel(0, 0, 1'b0);

        // Colour mode: c = -2 escapes at the bound check after one step, and
        // c = 0 runs to the full limit.
        push_write(CFG_COLOR_MODE, 32'h0000_0001);
        push_view(32'(-TWO_FX), 32'h0, 32'h0, 32'h0);
        push_pixel(0, 0, 1'b0);
        push_view(32'h0, 32'h0, 32'h0, 32'h0);
        push_pixel(0, 0, 1'b0);

        // Random phases, each under a fresh view; colour mode only in a few
        // phases to bound the long interior runs.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            colour = (phase % 4 == 3);
            calm   = (phase == RAND_PHASES - 1);
            case ($urandom_range(0, 3))
                0:
                    push_view(RE_ORIGIN_RESET, 32'(RE_STEP_RESET),
                              IM_ORIGIN_RESET, 32'(IM_STEP_RESET));
                1:
                    push_view(RE_ORIGIN_RESET + $urandom_range(0, 3 * ONE_FX),
                              $urandom_range(1, RE_STEP_RESET),
                              IM_ORIGIN_RESET + $urandom_range(0, ONE_FX + ONE_FX / 2),
                              $urandom_range(1, IM_STEP_RESET));
                2:
                    push_view($urandom, $urandom, $urandom, $urandom);
                default:
                    push_view($urandom_range(0, 7 * ONE_FX) - 7 * ONE_FX / 2,
                              $urandom_range(0, 1 << 24),
                              $urandom_range(0, 7 * ONE_FX) - 7 * ONE_FX / 2,
                              $urandom_range(0, 1 << 24));
            endcase
            push_write(CFG_COLOR_MODE, ($urandom << 1) | colour);
            if ($urandom_range(0, 3) == 0)
                push_write(CFG_INDEX_W'($urandom_range(CFG_COLOR_MODE + 1,
                                                       (1 << CFG_INDEX_W) - 1)),
                           $urandom);
            for (k = 0; k < PHASE_PIXELS; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_pixel($urandom_range(0, (1 << COL_W) - 1),
                               $urandom_range(0, (1 << ROW_W) - 1), calm);
                else
                    push_pixel($urandom_range(0, SCREEN_W - 1),
                               $urandom_range(0, SCREEN_H - 1), calm);
            end
        end

        // Drain: every command transferred, every result in, then a quiet tail.
        while (pending_cmds.size() != 0 || start || cfg_we)
            @(negedge clk);
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Checked %0d pixel results after %0d register writes.", n_checked, n_writes);
        $display("Pixels in gray mode: %0d, in colour mode: %0d.", n_gray, n_colour);
        if (n_errors == 0)
            $display("mandelbrot_escape_pixel_test: clean");
        else
            $display("mandelbrot_escape_pixel_test: errors");
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding.", expected_pixels.size());
        $display("mandelbrot_escape_pixel_test: errors");
        $finish;
    end

endmodule
